>>> design/dsss_bit_spreader_macros.svh
// ----------------------------------------------------------------------------
// DSSS bit spreader assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef DSSS_BIT_SPREADER_MACROS_SVH
`define DSSS_BIT_SPREADER_MACROS_SVH

// check only while out of reset
`define DSSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on every edge, reset included
`define DSSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/dsss_pkg.sv
// ----------------------------------------------------------------------------
// DSSS spreader package
// Shared constants, register codes and configuration write transaction type.
// ----------------------------------------------------------------------------
package dsss_pkg;

  localparam int CODE_REG_BITS   = 16;
  localparam int BITS_PER_BYTE   = 8;
  localparam int CODE_LEN_W      = 5;
  localparam int MAX_CODE_LENGTH = 16;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [CODE_REG_BITS-1:0] RESET_CODE_CHIPS  = 16'd39;
  localparam logic [CODE_LEN_W-1:0]    RESET_CODE_LENGTH = 5'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CODE_CHIPS  = 2'd0,
    CFG_CODE_LENGTH = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                     valid;
    logic [CFG_INDEX_W-1:0]   index;
    logic [CODE_REG_BITS-1:0] wdata;
  } cfg_wr_t;

endpackage

>>> design/dsss_bit_spreader.sv
// ----------------------------------------------------------------------------
// DSSS bit spreader
// Input bytes and chip bytes are registered. One chip byte per cycle unless
// out_stall_i holds the output; each input byte gives code-length chip bytes
// (7 at reset), and the next byte is taken in the cycle its predecessor's last
// chip byte is registered. Reset clears control state, loads the Barker-7 code.
// ----------------------------------------------------------------------------
`include "dsss_bit_spreader_macros.svh"

module dsss_bit_spreader
  import dsss_pkg::*;
#(
  parameter int MaxCodeLength = MAX_CODE_LENGTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [CODE_REG_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     frame_end_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               chip_byte_o,
  output logic                     run_last_o,
  output logic                     frame_last_o
);

  localparam int ChipW    = (MaxCodeLength > 1) ? $clog2(MaxCodeLength) : 1;
  localparam int CodeExtW = ((2 ** ChipW) > CODE_REG_BITS) ? (2 ** ChipW) : CODE_REG_BITS;

  cfg_wr_t                  cfg_wr;
  logic [CODE_REG_BITS-1:0] code_chips;
  logic [CodeExtW-1:0]      code_ext;
  logic [ChipW-1:0]         last_chip;

  logic                     busy_q, busy_d;
  logic [7:0]               data_q;
  logic                     fend_q;
  logic [2:0]               bit_q, bit_d;
  logic [ChipW-1:0]         chip_q, chip_d;
  logic [ChipW-1:0]         cnt_q, cnt_d;

  logic                     out_valid_q, out_valid_d;
  logic [7:0]               chip_byte_q, chip_byte_d;
  logic                     run_last_q;
  logic                     frame_last_q;

  logic                     out_adv;
  logic                     gen;
  logic                     run_end;
  logic                     in_accept;
  logic [2:0]               bit_nx;
  logic [ChipW-1:0]         chip_nx;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.wdata = cfg_wdata_i;

  dsss_cfg_regs #(
    .MaxCodeLength(MaxCodeLength)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .code_chips_o(code_chips),
    .last_chip_o (last_chip)
  );

  // chips past the code register read as zero
  assign code_ext = CodeExtW'(code_chips);

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign gen        = busy_q && out_adv;
  assign run_end    = (cnt_q == last_chip);
  assign in_stall_o = busy_q && !(out_adv && run_end);
  assign in_accept  = in_valid_i && !in_stall_o;

  // pack eight chips, walking the (bit, chip) position
  always_comb begin
    logic [2:0]       b;
    logic [ChipW-1:0] c;
    b           = bit_q;
    c           = chip_q;
    chip_byte_d = '0;
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      chip_byte_d[i] = code_ext[c] ~^ data_q[b];
      if (c == last_chip) begin
        c = '0;
        b = b + 3'd1;
      end else begin
        c = c + ChipW'(1);
      end
    end
    bit_nx  = b;
    chip_nx = c;
  end

  always_comb begin
    busy_d = busy_q;
    bit_d  = bit_q;
    chip_d = chip_q;
    cnt_d  = cnt_q;
    if (in_accept) begin
      busy_d = 1'b1;
      bit_d  = '0;
      chip_d = '0;
      cnt_d  = '0;
    end else if (gen) begin
      bit_d  = bit_nx;
      chip_d = chip_nx;
      cnt_d  = cnt_q + ChipW'(1);
      if (run_end) begin
        busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (gen) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      bit_q       <= '0;
      chip_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      bit_q       <= bit_d;
      chip_q      <= chip_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_byte_i;
      fend_q <= frame_end_i;
    end
    if (gen) begin
      chip_byte_q  <= chip_byte_d;
      run_last_q   <= run_end;
      frame_last_q <= run_end && fend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chip_byte_o  = chip_byte_q;
  assign run_last_o   = run_last_q;
  assign frame_last_o = frame_last_q;

  `DSSS_ASSERT(a_run_end_marked, (gen && run_end) |=> (out_valid_o && run_last_o), "run end not marked")
  `DSSS_ASSERT(a_accept_when_free, in_accept |-> (!busy_q || (gen && run_end)), "accept while busy")
  `DSSS_ASSERT(a_frame_on_run_end, (out_valid_o && frame_last_o) |-> run_last_o, "frame mark off run end")
  `DSSS_ASSERT_ALWAYS(a_cnt_in_range, busy_q |-> (cnt_q <= last_chip), "byte count overrun")

endmodule

>>> design/dsss_cfg_regs.sv
// ----------------------------------------------------------------------------
// DSSS configuration registers
// Holds the spreading code and its length; derives the clamped last chip index.
// ----------------------------------------------------------------------------
module dsss_cfg_regs
  import dsss_pkg::*;
#(
  parameter int MaxCodeLength = MAX_CODE_LENGTH,
  localparam int ChipW        = (MaxCodeLength > 1) ? $clog2(MaxCodeLength) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_wr_t                  cfg_wr_i,
  output logic [CODE_REG_BITS-1:0] code_chips_o,
  output logic [ChipW-1:0]         last_chip_o
);

  logic [CODE_REG_BITS-1:0] code_chips_q, code_chips_d;
  logic [CODE_LEN_W-1:0]    code_length_q, code_length_d;

  always_comb begin
    code_chips_d  = code_chips_q;
    code_length_d = code_length_q;
    if (cfg_wr_i.valid) begin
      unique case (cfg_reg_e'(cfg_wr_i.index))
        CFG_CODE_CHIPS:  code_chips_d  = cfg_wr_i.wdata;
        CFG_CODE_LENGTH: code_length_d = cfg_wr_i.wdata[CODE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_chips_q  <= RESET_CODE_CHIPS;
      code_length_q <= RESET_CODE_LENGTH;
    end else begin
      code_chips_q  <= code_chips_d;
      code_length_q <= code_length_d;
    end
  end

  // zero length acts as one chip, overlong lengths saturate
  always_comb begin
    if (code_length_q == '0) begin
      last_chip_o = '0;
    end else if (int'(code_length_q) > MaxCodeLength) begin
      last_chip_o = ChipW'(MaxCodeLength - 1);
    end else begin
      last_chip_o = ChipW'(code_length_q - CODE_LEN_W'(1));
    end
  end

  assign code_chips_o = code_chips_q;

endmodule

>>> bench/tb_dsss_bit_spreader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSSS bit spreader testbench
// Drives data bytes through the spreader under several code settings and
// checks every chip byte and its run and frame marks against a local model.
// A directed table comes first, then random phases. Each phase drains the
// pipeline and writes a new code before sending. The sender uses random
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_dsss_bit_spreader;
  import dsss_pkg::*;

  localparam int          RANDOM_BYTES   = 454;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_REPORTS    = 10;
  localparam int          NUM_ROWS       = 31;
  localparam int          CHIP_BITS      = MAX_CODE_LENGTH * BITS_PER_BYTE;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [7:0] chip_byte;
    logic       run_last;
    logic       frame_last;
  } chip_rec_t;

  typedef enum logic {ROW_WRITE, ROW_SPREAD} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [CODE_REG_BITS-1:0] wdata;
    logic [7:0]               data;
    logic                     fend;
    bit                       known;
    logic [CHIP_BITS-1:0]     bytes;
  } dir_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_INDEX_W-1:0]   cfg_index_i;
  logic [CODE_REG_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [7:0]               data_byte_i;
  logic                     frame_end_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [7:0]               chip_byte_o;
  logic                     run_last_o;
  logic                     frame_last_o;

  logic [CODE_REG_BITS-1:0] code_reg = RESET_CODE_CHIPS;
  logic [CODE_LEN_W-1:0]    len_reg  = RESET_CODE_LENGTH;
  chip_rec_t                pending_chips[$];
  int                       err_count    = 0;
  int unsigned              quiet_cycles = 0;
  int unsigned              burst_left   = 0;
  int unsigned              stall_left   = 0;
  stall_mode_e              stall_mode   = STALL_NONE;
  dir_row_t                 plan [NUM_ROWS];

  dsss_bit_spreader dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .chip_byte_o  (chip_byte_o),
    .run_last_o   (run_last_o),
    .frame_last_o (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned chips_per_bit(input logic [CODE_LEN_W-1:0] len);
    if (len == '0) return 1;
    if (len > MAX_CODE_LENGTH) return MAX_CODE_LENGTH;
    return 32'(len);
  endfunction

  function automatic logic [CHIP_BITS-1:0] spread_chips(input logic [7:0] data,
                                                        input logic [CODE_REG_BITS-1:0] code,
                                                        input int unsigned n);
    logic [CHIP_BITS-1:0] chips;
    int unsigned          pos;
    logic                 chip;
    chips = '0;
    pos   = 0;
    for (int j = 0; j < BITS_PER_BYTE; j++) begin
      for (int unsigned k = 0; k < n; k++) begin
        chip        = (k < CODE_REG_BITS) ? code[k] : 1'b0;
        chips[pos]  = data[j] ? chip : ~chip;
        pos++;
      end
    end
    return chips;
  endfunction

  function automatic void queue_run(input logic [7:0] data, input logic fend, input bit known,
                                    input logic [CHIP_BITS-1:0] typed_bytes);
    int unsigned          n;
    logic [CHIP_BITS-1:0] bytes;
    chip_rec_t            rec;
    n     = chips_per_bit(len_reg);
    bytes = known ? typed_bytes : spread_chips(data, code_reg, n);
    for (int unsigned k = 0; k < n; k++) begin
      rec.chip_byte  = bytes[8*k +: 8];
      rec.run_last   = (k == n - 1);
      rec.frame_last = (k == n - 1) && fend;
      pending_chips.push_back(rec);
    end
  endfunction

  function automatic void report_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  task automatic idle_cycle();
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_outputs();
    idle_cycle();
    while (pending_chips.size() != 0) idle_cycle();
    repeat (SETTLE_CYCLES) idle_cycle();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CODE_REG_BITS-1:0] wdata);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= wdata;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CODE_CHIPS:  code_reg = wdata;
      CFG_CODE_LENGTH: len_reg  = wdata[CODE_LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] data, input logic fend, input bit known,
                           input logic [CHIP_BITS-1:0] bytes);
    if (cfg_valid_i) idle_cycle();
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    frame_end_i <= fend;
    do @(posedge clk_i); while (in_stall_o);
    queue_run(data, fend, known, bytes);
  endtask

  task automatic pick_setting();
    logic [CODE_REG_BITS-1:0] code;
    logic [CODE_LEN_W-1:0]    len;
    case ($urandom_range(0, 5))
      0:       code = '0;
      1:       code = '1;
      2:       code = RESET_CODE_CHIPS;
      default: code = CODE_REG_BITS'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       len = 5'd1;
      1:       len = 5'd16;
      2:       len = 5'd0;
      3:       len = CODE_LEN_W'($urandom_range(17, 31));
      default: len = CODE_LEN_W'($urandom_range(1, 16));
    endcase
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_CODE_CHIPS, code);
      write_reg(CFG_CODE_LENGTH, {11'($urandom_range(0, 2047)), len});
    end else begin
      write_reg(CFG_CODE_LENGTH, {11'($urandom_range(0, 2047)), len});
      write_reg(CFG_CODE_CHIPS, code);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                CODE_REG_BITS'($urandom_range(0, 65535)));
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin : check_chips
    chip_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chips.size() == 0) begin
        report_error($sformatf("unexpected chip byte %02h run_last %0b frame_last %0b",
                               chip_byte_o, run_last_o, frame_last_o));
      end else begin
        want = pending_chips.pop_front();
        if (want.chip_byte !== chip_byte_o || want.run_last !== run_last_o ||
            want.frame_last !== frame_last_o)
          report_error($sformatf("chip byte exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.chip_byte, want.run_last, want.frame_last,
                                 chip_byte_o, run_last_o, frame_last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    frame_end_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CODE_CHIPS;
    cfg_wdata_i = '0;
    plan = '{
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'hFF, 1'b1, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h5A, 1'b0, 1'b0, '0},
      '{ROW_WRITE,  CFG_CODE_LENGTH, 16'h0001, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WRITE,  CFG_CODE_CHIPS,  16'h0001, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h00, 1'b0, 1'b1, 128'h00},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'hFF, 1'b1, 1'b1, 128'hFF},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'hA5, 1'b0, 1'b1, 128'hA5},
      '{ROW_WRITE,  CFG_CODE_CHIPS,  16'h0000, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h3C, 1'b1, 1'b1, 128'hC3},
      '{ROW_WRITE,  CFG_CODE_LENGTH, 16'h0000, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h81, 1'b0, 1'b1, 128'h7E},
      '{ROW_WRITE,  CFG_CODE_LENGTH, 16'h0008, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WRITE,  CFG_CODE_CHIPS,  16'h00FF, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'hA5, 1'b1, 1'b1, 128'hFF00FF0000FF00FF},
      '{ROW_WRITE,  CFG_CODE_LENGTH, 16'h0010, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WRITE,  CFG_CODE_CHIPS,  16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h00, 1'b1, 1'b1, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'hFF, 1'b0, 1'b1, '1},
      '{ROW_WRITE,  CFG_CODE_LENGTH, 16'h001F, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WRITE,  CFG_CODE_CHIPS,  16'hBEEF, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h5A, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'hFF, 1'b1, 1'b0, '0},
      '{ROW_WRITE,  CFG_CODE_LENGTH, 16'h0011, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h33, 1'b0, 1'b0, '0},
      '{ROW_WRITE,  CFG_SPARE_2,     16'h1234, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_WRITE,  CFG_SPARE_3,     16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'hC6, 1'b1, 1'b0, '0},
      '{ROW_WRITE,  CFG_CODE_LENGTH, 16'hFFE3, 8'h00, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h96, 1'b0, 1'b0, '0},
      '{ROW_SPREAD, CFG_CODE_CHIPS,  16'h0000, 8'h6B, 1'b1, 1'b0, '0}
    };
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (in_valid_i || pending_chips.size() != 0) drain_outputs();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_byte(plan[i].data, plan[i].fend, plan[i].known, plan[i].bytes);
      end
    end

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      drain_outputs();
      pick_setting();
      phase_len = $urandom_range(15, 45);
      repeat (phase_len) begin
        if (burst_left == 0) begin
          repeat ($urandom_range(0, 10)) idle_cycle();
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0, '0);
        sent++;
        if ($urandom_range(0, 99) == 0) drain_outputs();
      end
    end

    drain_outputs();
    if (err_count == 0 && pending_chips.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
